// File: rtl/pfx_pkg.sv
// shared constants and types for the postfix expression evaluator
package pfx_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
	localparam int CHAR_W      = 8;
	localparam int VAL_W       = 8;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
	localparam logic [CHAR_W-1:0] CH_OP_LO = 8'd42;
	localparam logic [CHAR_W-1:0] CH_OP_HI = 8'd47;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'd42;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'd47;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

endpackage

// File: rtl/pfx_ifs.sv
// valid/ready channel interfaces for characters and results
interface pfx_char_if;
	logic                         valid;
	logic                         ready;
	logic [pfx_pkg::CHAR_W-1:0]   char_code;
	logic                         is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface pfx_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [pfx_pkg::VAL_W-1:0] top_value;
	logic [1:0]                       status;

	modport source (output valid, output top_value, output status, input ready);
	modport sink   (input valid, input top_value, input status, output ready);
endinterface

// File: rtl/postfix_expression_evaluator_top.sv
// top level of the postfix expression evaluator: sequencer, alu, divider, stack ram
//
//   channel   dir   word fields            handshake
//   chars     in    char_code, is_last     valid / ready
//   result    out   top_value, status      valid / ready
//
// steps: a digit or ignored char is handled in decode; '+', '-', '*', ',' and
// '.' read the second entry and execute; '/' then runs the divider (one quotient
// bit per cycle in the divider) and writes back, unless the divisor is zero; the
// last char then reads the top entry out of the stack ram and emits it.
// the stack ram's single read port makes operators read their two entries in turn.
// reset: depth and error clear at once, the stack ram needs no clearing.
// a result waits in the output register; a new word is still taken, and only
// a later last char stalls until that register is free.
module postfix_expression_evaluator_top (
	input  logic                clk,
	input  logic                arst_n,
	pfx_char_if.sink            chars,
	pfx_result_if.source        result
);

	import pfx_pkg::*;

	// one-hot sequencer states
	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECODE = 8'b0000_0010,
		S_RD_A   = 8'b0000_0100,
		S_EXEC   = 8'b0000_1000,
		S_DIV    = 8'b0001_0000,
		S_WRITE  = 8'b0010_0000,
		S_RD_TOP = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t               state_q, state_d;
	logic [DEPTH_W-1:0]   depth_q, depth_d;
	status_t              err_q, err_d;
	logic                 out_valid_q, out_valid_d;

	// latched word
	logic [CHAR_W-1:0]    char_q;
	logic                 last_q;

	// operands and divider
	logic [VAL_W-1:0]     b_q;
	logic [VAL_W-1:0]     rem_q, quo_q, dvs_q;
	logic                 neg_q;
	logic [2:0]           cnt_q;

	// output register
	logic [VAL_W-1:0]     top_q;
	status_t              status_q;

	// stack ram port
	logic                 wr_en;
	logic [ADDR_W-1:0]    wr_addr;
	logic [VAL_W-1:0]     wr_data;
	logic [ADDR_W-1:0]    rd_addr;
	logic [VAL_W-1:0]     rd_data;

	logic                 accept;
	logic                 out_load;
	logic                 is_digit, is_op;
	logic [DEPTH_W-1:0]   depth_m1, depth_m2;
	state_t               tail_state;
	logic                 note;
	status_t              note_code;
	logic                 div_start;
	logic [VAL_W-1:0]     a_abs, b_abs;
	logic [15:0]          prod_full;
	logic [VAL_W:0]       trial;
	logic                 trial_ge;
	logic [VAL_W-1:0]     quo_signed;
	logic                 stack_empty;

	assign accept       = chars.valid && chars.ready;
	assign chars.ready  = (state_q == S_IDLE);

	assign result.valid     = out_valid_q;
	assign result.top_value = top_q;
	assign result.status    = status_q;

	assign is_digit   = (char_q >= CH_ZERO) && (char_q <= CH_NINE);
	assign is_op      = (char_q >= CH_OP_LO) && (char_q <= CH_OP_HI);
	assign depth_m1   = depth_q - DEPTH_W'(1);
	assign depth_m2   = depth_q - DEPTH_W'(2);
	assign tail_state = last_q ? S_RD_TOP : S_IDLE;
	assign stack_empty = (depth_q == '0);

	// second entry comes from the ram while the top sits in b_q
	assign rd_addr = (state_q == S_RD_A) ? depth_m2[ADDR_W-1:0] : depth_m1[ADDR_W-1:0];

	// magnitudes for the divider; -128 becomes 128 unsigned
	assign a_abs     = rd_data[VAL_W-1] ? (VAL_W'(0) - rd_data) : rd_data;
	assign b_abs     = b_q[VAL_W-1] ? (VAL_W'(0) - b_q) : b_q;
	assign prod_full = 16'(rd_data) * 16'(b_q);

	// one restoring division step per cycle
	assign trial      = {rem_q, quo_q[VAL_W-1]};
	assign trial_ge   = (trial >= {1'b0, dvs_q});
	assign quo_signed = neg_q ? (VAL_W'(0) - quo_q) : quo_q;

	assign out_load = (state_q == S_EMIT) && (!out_valid_q || result.ready);

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		err_d     = err_q;
		note      = 1'b0;
		note_code = ST_OK;
		wr_en     = 1'b0;
		wr_addr   = depth_m2[ADDR_W-1:0];
		wr_data   = '0;
		div_start = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = tail_state;
				if (is_digit) begin
					if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
						note      = 1'b1;
						note_code = ST_OVERFLOW;
					end else begin
						wr_en   = 1'b1;
						wr_addr = depth_q[ADDR_W-1:0];
						wr_data = char_q - CH_ZERO;
						depth_d = depth_q + DEPTH_W'(1);
					end
				end else if (is_op) begin
					if (depth_q < DEPTH_W'(2)) begin
						note      = 1'b1;
						note_code = ST_UNDERFLOW;
					end else begin
						state_d = S_RD_A;
					end
				end
			end
			S_RD_A: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = tail_state;
				case (char_q)
					CH_PLUS: begin
						wr_en   = 1'b1;
						wr_data = rd_data + b_q;
						depth_d = depth_m1;
					end
					CH_MINUS: begin
						wr_en   = 1'b1;
						wr_data = rd_data - b_q;
						depth_d = depth_m1;
					end
					CH_STAR: begin
						wr_en   = 1'b1;
						wr_data = prod_full[VAL_W-1:0];
						depth_d = depth_m1;
					end
					CH_SLASH: begin
						if (b_q == '0) begin
							note      = 1'b1;
							note_code = ST_DIVZERO;
							wr_en     = 1'b1;
							wr_data   = '0;
							depth_d   = depth_m1;
						end else begin
							div_start = 1'b1;
							state_d   = S_DIV;
						end
					end
					default: begin
						// ',' '.' and the rest of the operator range only pop
						depth_d = depth_m2;
					end
				endcase
			end
			S_DIV: begin
				if (cnt_q == 3'd7) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				wr_en   = 1'b1;
				wr_data = quo_signed;
				depth_d = depth_m1;
				state_d = tail_state;
			end
			S_RD_TOP: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_load) begin
					depth_d = '0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// first error of an expression sticks
		if (note && (err_q == ST_OK)) begin
			err_d = note_code;
		end
		if (out_load) begin
			err_d = ST_OK;
		end
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (out_load) begin
			out_valid_d = 1'b1;
		end else if (result.ready) begin
			out_valid_d = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			err_q       <= err_d;
			out_valid_q <= out_valid_d;
			if (div_start) begin
				cnt_q <= '0;
			end else if (state_q == S_DIV) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			char_q <= chars.char_code;
			last_q <= chars.is_last;
		end
		if (state_q == S_RD_A) begin
			b_q <= rd_data;
		end
		if (div_start) begin
			quo_q <= a_abs;
			dvs_q <= b_abs;
			rem_q <= '0;
			neg_q <= rd_data[VAL_W-1] ^ b_q[VAL_W-1];
		end else if (state_q == S_DIV) begin
			rem_q <= trial_ge ? VAL_W'(trial - {1'b0, dvs_q}) : trial[VAL_W-1:0];
			quo_q <= {quo_q[VAL_W-2:0], trial_ge};
		end
		if (out_load) begin
			top_q    <= stack_empty ? '0 : rd_data;
			status_q <= (stack_empty && (err_q == ST_OK)) ? ST_UNDERFLOW : err_q;
		end
	end

	pfx_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// a word taken always goes to decode next
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DECODE))
		else $error("accepted word not decoded");

	// a new result only comes out of the emit state
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result loaded outside emit");

	// emitting clears the expression state
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (depth_q == '0) && (err_q == ST_OK) && (state_q == S_IDLE))
		else $error("stack not cleared after result");

	// divider runs exactly eight steps before write back
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && (cnt_q == 3'd7)) |=> (state_q == S_WRITE))
		else $error("divider did not finish on time");

	// depth never passes the stack size
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (depth_q <= DEPTH_W'(STACK_DEPTH)) && (depth_d <= DEPTH_W'(STACK_DEPTH)))
		else $error("stack depth out of range");

endmodule

// File: rtl/pfx_ram.sv
// generic single-write, single-read ram with registered read data
module pfx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
